// File: rtl/core/tlbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_pkg - shared types and constants for the TLB lookup / fill core
// Entry count, field widths, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlbf_pkg;

    localparam int TLB_ENTRIES = 8;
    localparam int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    localparam int VA_W        = 32;
    localparam int PAGE_SHIFT  = 10;
    localparam int OFFSET_W    = PAGE_SHIFT;
    localparam int PAGE_W      = VA_W - PAGE_SHIFT;
    localparam int FRAME_W     = 16;
    localparam int DATE_W      = 32;
    localparam int PA_W        = FRAME_W + OFFSET_W;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_FILL   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } tlbf_state_t;

    typedef struct packed {
        logic latch_in;
        logic write_free;
        logic scan_start;
        logic scan_step;
        logic write_victim;
        logic load_out;
    } tlbf_cmd_t;

    typedef struct packed {
        logic is_fill;
        logic has_free;
        logic out_free;
        logic scan_last;
    } tlbf_status_t;

endpackage

// File: rtl/core/tlbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_ctrl - sequencing controller
// Accepts an item, then steps the datapath through lookup, free-slot fill or
// oldest-entry scan and replacement, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module tlbf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tlbf_pkg::tlbf_status_t status,
    output tlbf_pkg::tlbf_cmd_t   cmd
);

    tlbf_pkg::tlbf_state_t state_reg;
    tlbf_pkg::tlbf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlbf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            tlbf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = tlbf_pkg::ST_EVAL;
                end
            end
            tlbf_pkg::ST_EVAL: begin
                if (status.is_fill && !status.has_free) begin
                    cmd.scan_start = 1'b1;
                    state_next = (tlbf_pkg::TLB_ENTRIES > 1) ? tlbf_pkg::ST_SCAN
                                                             : tlbf_pkg::ST_WRITE;
                end else begin
                    cmd.write_free = status.is_fill;
                    if (status.out_free) begin
                        cmd.load_out = 1'b1;
                        state_next   = tlbf_pkg::ST_IDLE;
                    end else begin
                        state_next   = tlbf_pkg::ST_FINISH;
                    end
                end
            end
            tlbf_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = tlbf_pkg::ST_WRITE;
                end
            end
            tlbf_pkg::ST_WRITE: begin
                cmd.write_victim = 1'b1;
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = tlbf_pkg::ST_IDLE;
                end else begin
                    state_next   = tlbf_pkg::ST_FINISH;
                end
            end
            tlbf_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = tlbf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tlbf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_datapath - entry storage, match logic, victim scan and output stage
// Holds the entries, compares all pages in parallel, walks creation dates
// one entry per cycle for replacement and registers the result item.
// ----------------------------------------------------------------------------
module tlbf_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_mode,
    input  logic [tlbf_pkg::VA_W-1:0]       s_virtual_address,
    input  logic [tlbf_pkg::FRAME_W-1:0]    s_fill_frame,
    input  logic [tlbf_pkg::DATE_W-1:0]     s_request_date,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tlbf_pkg::PA_W-1:0]       m_physical_address,
    output logic                            m_hit,
    input  tlbf_pkg::tlbf_cmd_t             cmd,
    output tlbf_pkg::tlbf_status_t          status
);

    localparam int N = tlbf_pkg::TLB_ENTRIES;

    // latched request
    logic                              mode_reg;
    logic [tlbf_pkg::PAGE_W-1:0]       page_reg;
    logic [tlbf_pkg::OFFSET_W-1:0]     offset_reg;
    logic [tlbf_pkg::FRAME_W-1:0]      frame_in_reg;
    logic [tlbf_pkg::DATE_W-1:0]       date_reg;

    // entries
    logic [N-1:0]                      valid_reg;
    logic [tlbf_pkg::PAGE_W-1:0]       entry_page_reg    [N];
    logic [tlbf_pkg::FRAME_W-1:0]      entry_frame_reg   [N];
    logic [tlbf_pkg::DATE_W-1:0]       entry_created_reg [N];

    // victim scan
    logic [tlbf_pkg::IDX_W-1:0]        scan_idx_reg;
    logic [tlbf_pkg::IDX_W-1:0]        victim_reg;
    logic [tlbf_pkg::DATE_W-1:0]       best_date_reg;

    // output stage
    logic                              m_valid_reg;
    logic [tlbf_pkg::PA_W-1:0]         m_physical_address_reg;
    logic                              m_hit_reg;

    logic                              free_found;
    logic [tlbf_pkg::IDX_W-1:0]        free_idx;
    logic                              hit_found;
    logic [tlbf_pkg::IDX_W-1:0]        hit_idx;
    logic [tlbf_pkg::FRAME_W-1:0]      sel_frame;
    logic                              res_valid_addr;
    logic [tlbf_pkg::PA_W-1:0]         res_addr;
    logic                              wr_en;
    logic [tlbf_pkg::IDX_W-1:0]        wr_idx;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            mode_reg     <= s_mode;
            page_reg     <= s_virtual_address[tlbf_pkg::VA_W-1:tlbf_pkg::PAGE_SHIFT];
            offset_reg   <= s_virtual_address[tlbf_pkg::OFFSET_W-1:0];
            frame_in_reg <= s_fill_frame;
            date_reg     <= s_request_date;
        end
    end

    // lowest-index invalid entry and lowest-index matching entry
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        hit_found  = 1'b0;
        hit_idx    = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = tlbf_pkg::IDX_W'(i);
            end
            if (valid_reg[i] && (entry_page_reg[i] == page_reg)) begin
                hit_found = 1'b1;
                hit_idx   = tlbf_pkg::IDX_W'(i);
            end
        end
    end

    assign sel_frame      = (mode_reg == tlbf_pkg::MODE_FILL) ? frame_in_reg
                                                              : entry_frame_reg[hit_idx];
    assign res_valid_addr = (mode_reg == tlbf_pkg::MODE_FILL) || hit_found;
    assign res_addr       = res_valid_addr ? {sel_frame, offset_reg} : '0;

    assign wr_en  = cmd.write_free || cmd.write_victim;
    assign wr_idx = cmd.write_victim ? victim_reg : free_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_page_reg[wr_idx]    <= page_reg;
            entry_frame_reg[wr_idx]   <= frame_in_reg;
            entry_created_reg[wr_idx] <= date_reg;
        end
    end

    // oldest date, strict compare keeps the lowest index on ties
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_idx_reg  <= tlbf_pkg::IDX_W'(1);
            victim_reg    <= '0;
            best_date_reg <= entry_created_reg[0];
        end else if (cmd.scan_step) begin
            if (entry_created_reg[scan_idx_reg] < best_date_reg) begin
                best_date_reg <= entry_created_reg[scan_idx_reg];
                victim_reg    <= scan_idx_reg;
            end
            scan_idx_reg <= scan_idx_reg + tlbf_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_physical_address_reg <= res_addr;
            m_hit_reg              <= res_valid_addr;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_physical_address = m_physical_address_reg;
    assign m_hit              = m_hit_reg;

    assign status.is_fill   = (mode_reg == tlbf_pkg::MODE_FILL);
    assign status.has_free  = free_found;
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.scan_last = (scan_idx_reg == tlbf_pkg::IDX_W'(N - 1));

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.write_free && cmd.write_victim))
        else $error("free-slot and victim write in the same cycle");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken item");

    a_fill_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && mode_reg == tlbf_pkg::MODE_FILL) |=> (m_valid_reg && m_hit_reg))
        else $error("fill result without hit");

    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("entry valid bit dropped");

    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> valid_reg[$past(wr_idx)])
        else $error("written entry not valid");

endmodule

// File: rtl/core/tlb_lookup_fifo_fill_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_fill_core - fully associative TLB, 1 KiB pages
// Lookup returns (frame << 10) + offset of the lowest-index valid match, or
// 0 with hit low. Fill writes the lowest invalid entry, else replaces the
// entry with the oldest creation date (lowest index on ties).
// ----------------------------------------------------------------------------
// Sequence: lookups and free-slot fills are evaluated in ST_EVAL and loaded
//   into the output register from there; a fill into a full buffer first
//   runs the one-entry-per-cycle date scan (ST_SCAN) and the victim write.
// Throughput: one item in flight; a new item is accepted only once the last
//   result is loaded into the output register, which waits on m_ready.
// Reset: aresetn (sync, active low) invalidates every entry and empties the
//   output stage; entry contents are left as they are.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_fill_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [tlbf_pkg::VA_W-1:0]       s_virtual_address,
    input  logic [tlbf_pkg::FRAME_W-1:0]    s_fill_frame,
    input  logic [tlbf_pkg::DATE_W-1:0]     s_request_date,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tlbf_pkg::PA_W-1:0]       m_physical_address,
    output logic                            m_hit
);

    // command / status bundle between sequencer and datapath
    tlbf_pkg::tlbf_cmd_t    cmd;
    tlbf_pkg::tlbf_status_t status;

    // Controller: one item in flight. It latches the item, evaluates it,
    // runs the replacement scan when the buffer is full, and waits for the
    // output register to drain before loading the next result.
    tlbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: entries, parallel page compare, serial oldest-date search and
    // the registered output item. The output register lets a finished item
    // wait on m_ready while the next item is already accepted.
    tlbf_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_mode             (s_mode),
        .s_virtual_address  (s_virtual_address),
        .s_fill_frame       (s_fill_frame),
        .s_request_date     (s_request_date),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_physical_address (m_physical_address),
        .m_hit              (m_hit),
        .cmd                (cmd),
        .status             (status)
    );

endmodule
